// ===== rtl/itc_pkg.sv =====
package itc_pkg;

   // Fixed widths of the item and result fields
   localparam int ACTION_W  = 3;
   localparam int NUMBER_W  = 16;
   localparam int MASK_W    = 32;
   localparam int SUPPORT_W = 24;
   localparam int STATUS_W  = 2;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_CLEAR       = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_ADD         = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE      = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_TRANSACTION = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_FIND_NUMBER = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_FIND_ITEMS  = 3'd5;

   // Status codes
   localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STS_DUPLICATE = 2'd2;
   localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic wipe;      // write an empty entry at the sweep address and advance
      logic step;      // read or, on a clear, empty the sweep entry and advance
      logic load;      // take the request fields, rewind the sweep
      logic commit;    // final table write of an add or remove
      logic publish;   // load the result register
   } ctl_cmd_type;

   typedef struct packed {
      logic last_addr; // sweep address is at the final entry
   } dp_status_type;

endpackage

// ===== rtl/itemset_closure_table.sv =====
// Table of itemset nodes (number, item mask, closure mask, support) held in one
// TABLE_DEPTH-entry RAM. Every action, including clear, sweeps the whole table one
// entry per cycle; clear writes each entry empty, the others read it through the
// RAM's single read port. An item passes from acceptance through the sweep, a
// drain of the registered read, the final write of an add or remove, the loading
// of the result and a return to idle, where the next item is taken. Loading the
// result waits while the previous result is still held by rsp_stall. Exactly one
// result item follows each request item; the result register frees the request
// side as soon as the result is loaded. After reset the block empties the whole
// table and holds req_stall high while it does so.
module itemset_closure_table #(
   parameter int TABLE_DEPTH  = 64,
   parameter int ITEM_COUNT   = 32,
   parameter int SUPPORT_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [itc_pkg::ACTION_W-1:0]  req_action,
   input  logic [itc_pkg::NUMBER_W-1:0]  req_node_number,
   input  logic [itc_pkg::MASK_W-1:0]    req_item_mask,
   input  logic [itc_pkg::MASK_W-1:0]    req_closure_mask,
   input  logic [itc_pkg::SUPPORT_W-1:0] req_support_in,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [itc_pkg::STATUS_W-1:0]  rsp_status,
   output logic                          rsp_found,
   output logic [itc_pkg::NUMBER_W-1:0]  rsp_node_number_out,
   output logic [itc_pkg::MASK_W-1:0]    rsp_item_mask_out,
   output logic [itc_pkg::MASK_W-1:0]    rsp_closure_out,
   output logic [itc_pkg::SUPPORT_W-1:0] rsp_support_out
);

   import itc_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type sts;

   itc_controller u_ctl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd),
      .sts      (sts)
   );

   itc_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ITEM_COUNT  (ITEM_COUNT),
      .SUPPORT_BITS(SUPPORT_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_action         (req_action),
      .req_node_number    (req_node_number),
      .req_item_mask      (req_item_mask),
      .req_closure_mask   (req_closure_mask),
      .req_support_in     (req_support_in),
      .rsp_status         (rsp_status),
      .rsp_found          (rsp_found),
      .rsp_node_number_out(rsp_node_number_out),
      .rsp_item_mask_out  (rsp_item_mask_out),
      .rsp_closure_out    (rsp_closure_out),
      .rsp_support_out    (rsp_support_out)
   );

endmodule

// ===== rtl/itc_ram.sv =====
module itc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/itc_datapath.sv =====
module itc_datapath #(
   parameter int TABLE_DEPTH  = 64,
   parameter int ITEM_COUNT   = 32,
   parameter int SUPPORT_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  itc_pkg::ctl_cmd_type                cmd,
   output itc_pkg::dp_status_type              sts,
   input  logic [itc_pkg::ACTION_W-1:0]        req_action,
   input  logic [itc_pkg::NUMBER_W-1:0]        req_node_number,
   input  logic [itc_pkg::MASK_W-1:0]          req_item_mask,
   input  logic [itc_pkg::MASK_W-1:0]          req_closure_mask,
   input  logic [itc_pkg::SUPPORT_W-1:0]       req_support_in,
   output logic [itc_pkg::STATUS_W-1:0]        rsp_status,
   output logic                                rsp_found,
   output logic [itc_pkg::NUMBER_W-1:0]        rsp_node_number_out,
   output logic [itc_pkg::MASK_W-1:0]          rsp_item_mask_out,
   output logic [itc_pkg::MASK_W-1:0]          rsp_closure_out,
   output logic [itc_pkg::SUPPORT_W-1:0]       rsp_support_out
);

   import itc_pkg::*;

   localparam int AW        = $clog2(TABLE_DEPTH);
   localparam int IW        = (ITEM_COUNT < MASK_W) ? ITEM_COUNT : MASK_W;
   localparam int SB        = SUPPORT_BITS;
   localparam int SUP_LO    = 0;
   localparam int CLOS_LO   = SB;
   localparam int ITEMS_LO  = SB + IW;
   localparam int NUM_LO    = SB + 2 * IW;
   localparam int VALID_BIT = SB + 2 * IW + NUMBER_W;
   localparam int WORD_W    = VALID_BIT + 1;

   // Request held for the whole sweep
   logic [ACTION_W-1:0] act_ff;
   logic [NUMBER_W-1:0] num_ff;
   logic [IW-1:0]       items_ff;
   logic [IW-1:0]       clos_ff;
   logic [SB-1:0]       sup_ff;

   logic [AW-1:0]       addr_ff, addr_in;
   logic                rd_live_ff;
   logic [AW-1:0]       rd_addr_ff;

   logic                hit_ff;
   logic [AW-1:0]       hit_idx_ff;
   logic [WORD_W-1:0]   hit_word_ff;
   logic                free_found_ff;
   logic [AW-1:0]       free_idx_ff;

   logic [STATUS_W-1:0]  rsp_status_ff;
   logic                 rsp_found_ff;
   logic [NUMBER_W-1:0]  rsp_number_ff;
   logic [MASK_W-1:0]    rsp_items_ff;
   logic [MASK_W-1:0]    rsp_closure_ff;
   logic [SUPPORT_W-1:0] rsp_support_ff;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WORD_W-1:0]    wr_data;
   logic                 rd_en;
   logic [WORD_W-1:0]    rd_data;

   logic                 wipe_now;
   logic                 ent_valid;
   logic [NUMBER_W-1:0]  ent_num;
   logic [IW-1:0]        ent_items;
   logic [IW-1:0]        ent_clos;
   logic [SB-1:0]        ent_sup;
   logic                 key_match;
   logic                 subset;
   logic [SB-1:0]        sup_next;
   logic [STATUS_W-1:0]  status_in;
   logic                 found_in;

   itc_ram #(
      .WIDTH(WORD_W),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(addr_ff),
      .rd_data(rd_data)
   );

   assign sts.last_addr = (addr_ff == AW'(TABLE_DEPTH - 1));

   // A clear action empties each entry as the sweep passes it
   assign wipe_now = cmd.wipe || (cmd.step && act_ff == ACT_CLEAR);
   assign rd_en    = cmd.step && act_ff != ACT_CLEAR;

   always_comb begin
      addr_in = addr_ff;
      if (cmd.load) begin
         addr_in = '0;
      end else if (cmd.wipe || cmd.step) begin
         addr_in = sts.last_addr ? '0 : addr_ff + AW'(1);
      end
   end

   assign ent_valid = rd_data[VALID_BIT];
   assign ent_num   = rd_data[NUM_LO +: NUMBER_W];
   assign ent_items = rd_data[ITEMS_LO +: IW];
   assign ent_clos  = rd_data[CLOS_LO +: IW];
   assign ent_sup   = rd_data[SUP_LO +: SB];

   always_comb begin
      case (act_ff) inside
         ACT_ADD, ACT_REMOVE, ACT_FIND_NUMBER: key_match = (ent_num == num_ff);
         ACT_FIND_ITEMS:                       key_match = (ent_items == items_ff);
         default:                              key_match = 1'b0;
      endcase
   end

   assign subset   = ((ent_items & ~items_ff) == '0);
   // Hold the support at its maximum once saturated
   assign sup_next = (&ent_sup) ? ent_sup : ent_sup + SB'(1);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = '0;
      if (wipe_now) begin
         wr_en = 1'b1;
      end else if (cmd.commit) begin
         if (act_ff == ACT_ADD) begin
            wr_en   = !hit_ff && free_found_ff;
            wr_addr = free_idx_ff;
            wr_data = {1'b1, num_ff, items_ff, clos_ff, sup_ff};
         end else if (act_ff == ACT_REMOVE) begin
            wr_en   = hit_ff;
            wr_addr = hit_idx_ff;
         end
      end else if (rd_live_ff && act_ff == ACT_TRANSACTION && ent_valid && subset) begin
         wr_en   = 1'b1;
         wr_addr = rd_addr_ff;
         wr_data = {1'b1, ent_num, ent_items, ent_clos & items_ff, sup_next};
      end
   end

   always_comb begin
      case (act_ff) inside
         ACT_ADD: begin
            if (hit_ff) begin
               status_in = STS_DUPLICATE;
            end else begin
               status_in = free_found_ff ? STS_OK : STS_FULL;
            end
         end
         ACT_REMOVE, ACT_FIND_NUMBER, ACT_FIND_ITEMS: begin
            status_in = hit_ff ? STS_OK : STS_NOT_FOUND;
         end
         default: status_in = STS_OK;
      endcase
   end

   assign found_in = hit_ff && (act_ff == ACT_FIND_NUMBER || act_ff == ACT_FIND_ITEMS);

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= '0;
         rd_live_ff    <= 1'b0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         addr_ff    <= addr_in;
         rd_live_ff <= rd_en;
         if (cmd.load) begin
            hit_ff        <= 1'b0;
            free_found_ff <= 1'b0;
         end else if (rd_live_ff) begin
            // Keep the lowest matching and the lowest free entry
            if (ent_valid && key_match && !hit_ff) begin
               hit_ff <= 1'b1;
            end
            if (!ent_valid && !free_found_ff) begin
               free_found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= addr_ff;
      if (cmd.load) begin
         act_ff   <= req_action;
         num_ff   <= req_node_number;
         items_ff <= req_item_mask[IW-1:0];
         clos_ff  <= req_closure_mask[IW-1:0];
         sup_ff   <= SB'(req_support_in);
      end
      if (rd_live_ff && ent_valid && key_match && !hit_ff) begin
         hit_idx_ff  <= rd_addr_ff;
         hit_word_ff <= rd_data;
      end
      if (rd_live_ff && !ent_valid && !free_found_ff) begin
         free_idx_ff <= rd_addr_ff;
      end
      if (cmd.publish) begin
         rsp_status_ff  <= status_in;
         rsp_found_ff   <= found_in;
         rsp_number_ff  <= found_in ? hit_word_ff[NUM_LO +: NUMBER_W] : '0;
         rsp_items_ff   <= found_in ? MASK_W'(hit_word_ff[ITEMS_LO +: IW]) : '0;
         rsp_closure_ff <= found_in ? MASK_W'(hit_word_ff[CLOS_LO +: IW]) : '0;
         rsp_support_ff <= found_in ? SUPPORT_W'(hit_word_ff[SUP_LO +: SB]) : '0;
      end
   end

   assign rsp_status          = rsp_status_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_node_number_out = rsp_number_ff;
   assign rsp_item_mask_out   = rsp_items_ff;
   assign rsp_closure_out     = rsp_closure_ff;
   assign rsp_support_out     = rsp_support_ff;

   // The single write port is never claimed by two sources at once
   a_commit_vs_update: assert property (@(posedge clock) disable iff (reset)
      !(cmd.commit && rd_live_ff))
      else $error("commit write collides with a sweep write-back");

   a_wipe_vs_update: assert property (@(posedge clock) disable iff (reset)
      !(wipe_now && rd_live_ff))
      else $error("wipe write collides with a sweep write-back");

   a_addr_range: assert property (@(posedge clock) disable iff (reset)
      addr_ff <= AW'(TABLE_DEPTH - 1))
      else $error("sweep address beyond the table");

endmodule

// ===== rtl/itc_controller.sv =====
module itc_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output itc_pkg::ctl_cmd_type   cmd,
   input  itc_pkg::dp_status_type sts
);

   import itc_pkg::*;

   typedef enum logic [2:0] {
      ST_WIPE,
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT,
      ST_RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd         = '0;
      cmd.wipe    = (state_ff == ST_WIPE);
      cmd.step    = (state_ff == ST_SCAN);
      cmd.load    = (state_ff == ST_IDLE) && req_valid;
      cmd.commit  = (state_ff == ST_COMMIT);
      cmd.publish = (state_ff == ST_RESPOND) && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_WIPE:    if (sts.last_addr) state_in = ST_IDLE;
         ST_IDLE:    if (req_valid) state_in = ST_SCAN;
         ST_SCAN:    if (sts.last_addr) state_in = ST_DRAIN;
         ST_DRAIN:   state_in = ST_COMMIT;
         ST_COMMIT:  state_in = ST_RESPOND;
         ST_RESPOND: if (cmd.publish) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while still waiting");

   a_drain_after_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRAIN |-> $past(state_ff) == ST_SCAN)
      else $error("drain entered without a finished sweep");

   a_commit_to_respond: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMMIT |=> state_ff == ST_RESPOND)
      else $error("commit not followed by respond");

endmodule

// ===== test/tb_itemset_closure_table.sv =====
`timescale 1ns / 100ps

import itc_pkg::*;

localparam int TABLE_SLOTS = 64;
localparam logic [SUPPORT_W-1:0] SUPPORT_CEILING = '1;
// codes the block must treat as no-ops
localparam logic [ACTION_W-1:0] ACT_SPARE_LO = 3'd6;
localparam logic [ACTION_W-1:0] ACT_SPARE_HI = 3'd7;

typedef struct packed {
   logic [ACTION_W-1:0]  action;
   logic [NUMBER_W-1:0]  number;
   logic [MASK_W-1:0]    items;
   logic [MASK_W-1:0]    closure;
   logic [SUPPORT_W-1:0] support;
} node_request_type;

typedef struct packed {
   logic [STATUS_W-1:0]  status;
   logic                 found;
   logic [NUMBER_W-1:0]  number;
   logic [MASK_W-1:0]    items;
   logic [MASK_W-1:0]    closure;
   logic [SUPPORT_W-1:0] support;
} node_result_type;

class node_table_shadow;
   bit                   live [TABLE_SLOTS];
   logic [NUMBER_W-1:0]  slot_number [TABLE_SLOTS];
   logic [MASK_W-1:0]    slot_items [TABLE_SLOTS];
   logic [MASK_W-1:0]    slot_closure [TABLE_SLOTS];
   logic [SUPPORT_W-1:0] slot_support [TABLE_SLOTS];
   node_result_type      awaited_rsp [$];
   int                   mismatches;
   int                   actions_seen [8];
   int                   status_seen [4];
   int                   finds_hit;

   function new();
      mismatches = 0;
      finds_hit = 0;
      foreach (live[i]) live[i] = 1'b0;
      foreach (actions_seen[i]) actions_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
   endfunction

   function int slot_of_number(logic [NUMBER_W-1:0] num);
      for (int i = 0; i < TABLE_SLOTS; i++)
         if (live[i] && slot_number[i] == num) return i;
      return -1;
   endfunction

   function int slot_of_items(logic [MASK_W-1:0] mask);
      for (int i = 0; i < TABLE_SLOTS; i++)
         if (live[i] && slot_items[i] == mask) return i;
      return -1;
   endfunction

   function int live_count();
      int n;
      n = 0;
      foreach (live[i]) if (live[i]) n++;
      return n;
   endfunction

   function int any_live_slot();
      int picks [$];
      foreach (live[i]) if (live[i]) picks.push_back(i);
      if (picks.size() == 0) return -1;
      return picks[$urandom_range(picks.size() - 1)];
   endfunction

   // Apply one accepted item to the shadow table and queue the result it must give
   function void note_request(node_request_type rq);
      node_result_type res;
      int slot;
      int hit;
      res = '0;
      res.status = STS_OK;
      hit = -1;
      actions_seen[rq.action]++;
      case (rq.action)
         ACT_CLEAR: begin
            foreach (live[i]) live[i] = 1'b0;
         end
         ACT_ADD: begin
            if (slot_of_number(rq.number) >= 0) begin
               res.status = STS_DUPLICATE;
            end else begin
               res.status = STS_FULL;
               for (int i = 0; i < TABLE_SLOTS; i++) begin
                  if (!live[i] && res.status == STS_FULL) begin
                     live[i] = 1'b1;
                     slot_number[i] = rq.number;
                     slot_items[i] = rq.items;
                     slot_closure[i] = rq.closure;
                     slot_support[i] = rq.support;
                     res.status = STS_OK;
                  end
               end
            end
         end
         ACT_REMOVE: begin
            slot = slot_of_number(rq.number);
            if (slot >= 0) live[slot] = 1'b0;
            else res.status = STS_NOT_FOUND;
         end
         ACT_TRANSACTION: begin
            for (int i = 0; i < TABLE_SLOTS; i++) begin
               if (live[i] && (slot_items[i] & ~rq.items) == '0) begin
                  slot_closure[i] &= rq.items;
                  if (slot_support[i] != SUPPORT_CEILING) slot_support[i]++;
               end
            end
         end
         ACT_FIND_NUMBER: begin
            hit = slot_of_number(rq.number);
            if (hit < 0) res.status = STS_NOT_FOUND;
         end
         ACT_FIND_ITEMS: begin
            hit = slot_of_items(rq.items);
            if (hit < 0) res.status = STS_NOT_FOUND;
         end
         default: ;
      endcase
      if (hit >= 0) begin
         res.found = 1'b1;
         res.number = slot_number[hit];
         res.items = slot_items[hit];
         res.closure = slot_closure[hit];
         res.support = slot_support[hit];
      end
      awaited_rsp.push_back(res);
   endfunction

   function void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   function void check_response(node_result_type got);
      node_result_type want;
      if (awaited_rsp.size() == 0) begin
         $display("%0t: result with nothing awaited, status %0d", $time, got.status);
         mismatches++;
         return;
      end
      want = awaited_rsp.pop_front();
      status_seen[got.status]++;
      if (got.found === 1'b1) finds_hit++;
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("found", 32'(want.found), 32'(got.found));
      compare_field("node number", 32'(want.number), 32'(got.number));
      compare_field("item mask", want.items, got.items);
      compare_field("closure", want.closure, got.closure);
      compare_field("support", 32'(want.support), 32'(got.support));
   endfunction

   function void report_leftovers();
      if (awaited_rsp.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, awaited_rsp.size());
         mismatches++;
      end
   endfunction
endclass

module tb_itemset_closure_table;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int DRAIN_CYCLES   = 100;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int PHASE_ITEMS    = 380;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [ACTION_W-1:0]  req_action;
   logic [NUMBER_W-1:0]  req_node_number;
   logic [MASK_W-1:0]    req_item_mask;
   logic [MASK_W-1:0]    req_closure_mask;
   logic [SUPPORT_W-1:0] req_support_in;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 rsp_found;
   logic [NUMBER_W-1:0]  rsp_node_number_out;
   logic [MASK_W-1:0]    rsp_item_mask_out;
   logic [MASK_W-1:0]    rsp_closure_out;
   logic [SUPPORT_W-1:0] rsp_support_out;

   node_table_shadow table_shadow;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int holdoff_left = 0;
   int cycle_count = 0;
   int items_sent = 0;

   itemset_closure_table #(
      .TABLE_DEPTH(TABLE_SLOTS),
      .ITEM_COUNT(32),
      .SUPPORT_BITS(24)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_node_number(req_node_number),
      .req_item_mask(req_item_mask),
      .req_closure_mask(req_closure_mask),
      .req_support_in(req_support_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_found(rsp_found),
      .rsp_node_number_out(rsp_node_number_out),
      .rsp_item_mask_out(rsp_item_mask_out),
      .rsp_closure_out(rsp_closure_out),
      .rsp_support_out(rsp_support_out)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         table_shadow.note_request({req_action, req_node_number, req_item_mask,
                                    req_closure_mask, req_support_in});
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         table_shadow.check_response({rsp_status, rsp_found, rsp_node_number_out,
                                      rsp_item_mask_out, rsp_closure_out, rsp_support_out});
   end

   // Result side: a long hold-off when asked for, random stalls otherwise
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (holdoff_left > 0) begin
            rsp_stall = 1'b1;
            holdoff_left--;
         end else begin
            rsp_stall = ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   task automatic send_item(node_request_type rq);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      {req_action, req_node_number, req_item_mask, req_closure_mask, req_support_in} = rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      items_sent++;
   endtask

   function automatic node_request_type make_req(logic [ACTION_W-1:0] action,
                                                 logic [NUMBER_W-1:0] num,
                                                 logic [MASK_W-1:0] items,
                                                 logic [MASK_W-1:0] closure,
                                                 logic [SUPPORT_W-1:0] support);
      return {action, num, items, closure, support};
   endfunction

   function automatic logic [NUMBER_W-1:0] pick_number(int reuse_pct);
      int slot;
      slot = table_shadow.any_live_slot();
      if (slot >= 0 && $urandom_range(99) < reuse_pct) return table_shadow.slot_number[slot];
      if ($urandom_range(9) == 0) return NUMBER_W'($urandom);
      return NUMBER_W'($urandom_range(127));
   endfunction

   function automatic logic [MASK_W-1:0] sparse_mask();
      case ($urandom_range(9))
         0: return $urandom;
         1: return '0;
         default: return $urandom & $urandom & $urandom;
      endcase
   endfunction

   // Dense masks, often a superset of a stored itemset, so that nodes get updated
   function automatic logic [MASK_W-1:0] transaction_mask();
      int slot;
      slot = table_shadow.any_live_slot();
      case ($urandom_range(9))
         0: return $urandom;
         1: return '1;
         2: return $urandom | $urandom;
         default: begin
            if (slot < 0) return $urandom | $urandom;
            return table_shadow.slot_items[slot] | ($urandom & $urandom);
         end
      endcase
   endfunction

   function automatic logic [SUPPORT_W-1:0] support_value();
      case ($urandom_range(19))
         0: return SUPPORT_CEILING - SUPPORT_W'($urandom_range(2));
         1: return SUPPORT_W'($urandom);
         default: return SUPPORT_W'($urandom_range(50));
      endcase
   endfunction

   function automatic node_request_type random_item();
      node_request_type rq;
      int pick;
      int slot;
      pick = $urandom_range(99);
      slot = table_shadow.any_live_slot();
      rq.number = pick_number(60);
      rq.items = sparse_mask();
      rq.closure = ($urandom_range(3) == 0) ? '1 : $urandom;
      rq.support = support_value();
      if (pick < 1) begin
         rq.action = ACT_CLEAR;
      end else if (pick < 3) begin
         rq.action = $urandom_range(1) ? ACT_SPARE_LO : ACT_SPARE_HI;
      end else if (pick < 33) begin
         rq.action = ACT_ADD;
         rq.number = pick_number(20);
      end else if (pick < 45) begin
         rq.action = ACT_REMOVE;
      end else if (pick < 70) begin
         rq.action = ACT_TRANSACTION;
         rq.items = transaction_mask();
      end else if (pick < 85) begin
         rq.action = ACT_FIND_NUMBER;
      end else begin
         rq.action = ACT_FIND_ITEMS;
         if (slot >= 0 && $urandom_range(9) < 7) rq.items = table_shadow.slot_items[slot];
      end
      return rq;
   endfunction

   // Add fresh nodes until the table overflows twice, then run a few transactions over it
   task automatic fill_table(inout int sent);
      node_request_type rq;
      int overflows;
      overflows = 0;
      while (overflows < 2) begin
         rq = random_item();
         rq.action = ACT_ADD;
         if (table_shadow.live_count() >= TABLE_SLOTS) begin
            overflows++;
         end else begin
            while (table_shadow.slot_of_number(rq.number) >= 0)
               rq.number = NUMBER_W'($urandom);
         end
         send_item(rq);
         sent++;
      end
      repeat (4) begin
         rq = random_item();
         rq.action = ACT_TRANSACTION;
         rq.items = transaction_mask();
         send_item(rq);
         sent++;
      end
   endtask

   task automatic run_phase(int idle_pct, int stall_pct, bit squeeze);
      int sent_here;
      sent_here = 0;
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      if (squeeze) holdoff_left = HOLDOFF_CYCLES;
      while (sent_here < PHASE_ITEMS) begin
         if ($urandom_range(99) < 2) begin
            fill_table(sent_here);
         end else begin
            send_item(random_item());
            sent_here++;
         end
      end
      req_valid = 1'b0;
      // hold the sender until every outstanding result is back
      while (table_shadow.awaited_rsp.size() != 0) @(negedge clock);
   endtask

   task automatic directed_items();
      send_item(make_req(ACT_FIND_NUMBER, '0, '0, '0, '0));
      send_item(make_req(ACT_REMOVE, 16'h0005, '0, '0, '0));
      send_item(make_req(ACT_FIND_ITEMS, '0, '0, '0, '0));
      send_item(make_req(ACT_TRANSACTION, '0, '1, '0, '0));
      send_item(make_req(ACT_ADD, '1, '1, '1, SUPPORT_CEILING));
      send_item(make_req(ACT_ADD, '0, '0, '0, '0));
      send_item(make_req(ACT_ADD, '1, 32'h1234_5678, '0, 24'd5));
      send_item(make_req(ACT_TRANSACTION, '0, '1, '0, '0));
      send_item(make_req(ACT_FIND_NUMBER, '1, '0, '0, '0));
      send_item(make_req(ACT_ADD, 16'd7, 32'h0000_00F0, '1, SUPPORT_CEILING - 1'b1));
      send_item(make_req(ACT_ADD, 16'd8, 32'h0000_00F0, 32'hAAAA_AAAA, 24'd3));
      send_item(make_req(ACT_TRANSACTION, '0, 32'h0F0F_00F0, '0, '0));
      send_item(make_req(ACT_TRANSACTION, '0, 32'h0000_0070, '0, '0));
      send_item(make_req(ACT_FIND_ITEMS, '0, 32'h0000_00F0, '0, '0));
      send_item(make_req(ACT_FIND_NUMBER, 16'd7, '0, '0, '0));
      send_item(make_req(ACT_REMOVE, '1, '0, '0, '0));
      send_item(make_req(ACT_ADD, 16'd9, 32'h8000_0001, 32'h5555_5555, 24'h80_0001));
      send_item(make_req(ACT_FIND_NUMBER, 16'd9, '0, '0, '0));
      send_item(make_req(ACT_FIND_ITEMS, '0, 32'h8000_0001, '0, '0));
      send_item(make_req(ACT_SPARE_LO, '1, '1, '1, '1));
      send_item(make_req(ACT_SPARE_HI, '1, '1, '1, '1));
      send_item(make_req(ACT_CLEAR, '1, '1, '1, '1));
      send_item(make_req(ACT_FIND_NUMBER, '0, '0, '0, '0));
      send_item(make_req(ACT_FIND_ITEMS, '0, '0, '0, '0));
   endtask

   initial begin
      table_shadow = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_CLEAR;
      req_node_number = '0;
      req_item_mask = '0;
      req_closure_mask = '0;
      req_support_in = '0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      directed_items();
      run_phase(0, 0, 1'b1);
      run_phase(55, 0, 1'b0);
      run_phase(0, 55, 1'b0);
      run_phase(31, 31, 1'b0);

      repeat (DRAIN_CYCLES) @(negedge clock);
      table_shadow.report_leftovers();
      $display("Covered %0d items: %0d adds, %0d removes, %0d transactions, %0d finds, %0d clears",
               items_sent, table_shadow.actions_seen[ACT_ADD],
               table_shadow.actions_seen[ACT_REMOVE],
               table_shadow.actions_seen[ACT_TRANSACTION],
               table_shadow.actions_seen[ACT_FIND_NUMBER]
                  + table_shadow.actions_seen[ACT_FIND_ITEMS],
               table_shadow.actions_seen[ACT_CLEAR]);
      $display("Lookups hit %0d times; table full %0d, duplicate %0d, not found %0d",
               table_shadow.finds_hit, table_shadow.status_seen[STS_FULL],
               table_shadow.status_seen[STS_DUPLICATE],
               table_shadow.status_seen[STS_NOT_FOUND]);
      if (table_shadow.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/itc_pkg.sv
rtl/itc_ram.sv
rtl/itc_datapath.sv
rtl/itc_controller.sv
rtl/itemset_closure_table.sv
test/tb_itemset_closure_table.sv
